>>> hw/rtl/gbc_pkg.sv
package gbc_pkg;

  // Frame limits and store geometry
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int STORED_ROWS = 8;
  localparam int HALF_TAPS   = 3;
  localparam int STORE_DEPTH = STORED_ROWS * MAX_WIDTH;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int TAP_W       = 3;
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(2 * HALF_TAPS);

  localparam int DIM_W  = 13;
  localparam int POS_W  = 12;
  localparam int WARM_W = 15;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 40;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WEIGHT_CTR   = 3'd2;
  localparam logic [2:0] REG_WEIGHT_ONE   = 3'd3;
  localparam logic [2:0] REG_WEIGHT_TWO   = 3'd4;
  localparam logic [2:0] REG_WEIGHT_THREE = 3'd5;

  localparam logic [15:0] RST_WEIGHT_CTR   = 16'd26152;
  localparam logic [15:0] RST_WEIGHT_ONE   = 16'd15862;
  localparam logic [15:0] RST_WEIGHT_TWO   = 16'd3539;
  localparam logic [15:0] RST_WEIGHT_THREE = 16'd291;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

endpackage

>>> hw/rtl/gbc_if.sv
interface gbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       flush;
  modport source (output valid, in_red, in_green, in_blue, flush, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

interface gbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       last_pixel;
  modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

>>> hw/rtl/gbc_mac.sv
module gbc_mac (
  input  logic              clk,
  input  gbc_pkg::mac_ctl_t ctl,
  input  logic [23:0]       px,
  input  logic [31:0]       wxy,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  logic [gbc_pkg::PROD_W-1:0] prod_r [3];
  logic [gbc_pkg::ACC_W-1:0]  acc_r  [3];
  logic [7:0]                 res    [3];

  // Multiply each channel by the joint weight, then accumulate
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl.mul_en) begin
        prod_r[i] <= px[8*(2-i) +: 8] * wxy;
      end
      if (ctl.clear) begin
        acc_r[i] <= '0;
      end else if (ctl.acc_en) begin
        acc_r[i] <= acc_r[i] + gbc_pkg::ACC_W'(prod_r[i]);
      end
    end
  end

  // Round half up at bit 32 and saturate
  always_comb begin
    logic [gbc_pkg::ACC_W-1:0] rnd;
    for (int i = 0; i < 3; i++) begin
      rnd = acc_r[i] + gbc_pkg::ACC_W'(33'h080000000);
      res[i] = (rnd[gbc_pkg::ACC_W-1:40] != '0) ? 8'hFF : rnd[39:32];
    end
  end

  assign red   = res[0];
  assign green = res[1];
  assign blue  = res[2];

endmodule

>>> hw/rtl/gaussian_blur_clamped_top.sv
// 7x7 Gaussian blur of an RGB raster stream, edges replicated.
// Channels: in_if carries one pixel per beat (red, green, blue, flush); out_if
// carries one blurred pixel per beat with last_pixel on the final one of the
// frame. The cfg port writes width, height and four Q0.16 1D weights, one
// register per cycle with cfg_wr_en high; write only while the block is idle.
// Output for pixel p leaves on the beat that follows pixel p by 3*width+3 input
// beats; flush beats after the frame supply these, flushes before frame end are
// dropped. Pixels sent after the frame is complete are taken but discarded.
// A beat that gives a result holds off the next beat while the 49 window taps
// are fetched one by one through the pixel store's one read port (row multiply,
// read, multiply, add) and the result is finished. A beat that gives no result
// leaves the input ready. A waiting result sits in an output register; the next
// beat is taken meanwhile and only the finish of the next result waits for the
// receiver.
// Reset clears all counters and restores register defaults; the pixel store is
// not cleared, every window entry is written before it is read.
module gaussian_blur_clamped_top (
  input  logic        clk,
  input  logic        rst_n,
  gbc_in_if.sink      in_if,
  gbc_out_if.source   out_if,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ROW  = 6'b000010,
    ST_READ = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam int DW  = gbc_pkg::DIM_W;
  localparam int PW  = gbc_pkg::POS_W;
  localparam int AW  = gbc_pkg::STORE_AW;
  localparam int WW  = gbc_pkg::WARM_W;
  localparam int TW  = gbc_pkg::TAP_W;

  state_t state_r, state_nxt;

  logic [DW-1:0] width_r, height_r;
  logic [15:0]   wgt_r [4];

  logic [PW-1:0] in_col_r, out_col_r, out_row_r;
  logic [DW-1:0] in_row_r;
  logic [WW-1:0] warm_r;
  logic [TW-1:0] dy_r, dx_r;

  logic [AW-1:0] row_base_r;
  logic [31:0]   wxy_r;
  logic [23:0]   mem [gbc_pkg::STORE_DEPTH];
  logic [23:0]   rd_data_r;

  logic          out_valid_r;
  logic [7:0]    out_red_r, out_green_r, out_blue_r;
  logic          out_last_r;

  logic [DW-1:0] w_eff, h_eff;
  logic [WW-1:0] lag;
  logic          accept, input_done, advance, warming, out_free, last;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [PW-1:0] wr_col, r_cl, c_cl;
  logic [1:0]    wy_sel, wx_sel;
  logic [7:0]    mac_red, mac_green, mac_blue;
  gbc_pkg::mac_ctl_t mac_ctl;

  // Clamp frame size to the supported range
  assign w_eff = (width_r == '0) ? DW'(1) :
                 (width_r > DW'(gbc_pkg::MAX_WIDTH)) ? DW'(gbc_pkg::MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? DW'(1) :
                 (height_r > DW'(gbc_pkg::MAX_HEIGHT)) ? DW'(gbc_pkg::MAX_HEIGHT) : height_r;
  assign lag   = WW'(gbc_pkg::HALF_TAPS) * WW'(w_eff) + WW'(gbc_pkg::HALF_TAPS);

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign input_done  = (in_row_r >= h_eff);
  assign advance     = accept && (input_done || !in_if.flush);
  assign warming     = (warm_r < lag);
  assign out_free    = !out_valid_r || out_if.ready;
  assign last        = (DW'(out_row_r) + DW'(1) >= h_eff) && (DW'(out_col_r) + DW'(1) >= w_eff);

  // Store address of the incoming pixel
  always_comb begin
    logic [2*DW-1:0] prod;
    wr_col  = (DW'(in_col_r) < w_eff) ? in_col_r : PW'(w_eff - DW'(1));
    prod    = in_row_r * w_eff;
    wr_addr = prod[AW-1:0] + AW'(wr_col);
    wr_en   = accept && !input_done && !in_if.flush;
  end

  // Clamp window coordinates and pick tap weights
  always_comb begin
    logic signed [DW+1:0] rs, cs;
    rs = $signed({2'b00, 1'b0, out_row_r}) + $signed({{(DW-1){1'b0}}, dy_r})
         - (DW+2)'(gbc_pkg::HALF_TAPS);
    cs = $signed({2'b00, 1'b0, out_col_r}) + $signed({{(DW-1){1'b0}}, dx_r})
         - (DW+2)'(gbc_pkg::HALF_TAPS);
    if (rs < 0) r_cl = '0;
    else if (rs > $signed({2'b00, h_eff - DW'(1)})) r_cl = PW'(h_eff - DW'(1));
    else r_cl = rs[PW-1:0];
    if (cs < 0) c_cl = '0;
    else if (cs > $signed({2'b00, w_eff - DW'(1)})) c_cl = PW'(w_eff - DW'(1));
    else c_cl = cs[PW-1:0];
    wy_sel = (dy_r < TW'(gbc_pkg::HALF_TAPS)) ? 2'(TW'(gbc_pkg::HALF_TAPS) - dy_r)
                                              : 2'(dy_r - TW'(gbc_pkg::HALF_TAPS));
    wx_sel = (dx_r < TW'(gbc_pkg::HALF_TAPS)) ? 2'(TW'(gbc_pkg::HALF_TAPS) - dx_r)
                                              : 2'(dx_r - TW'(gbc_pkg::HALF_TAPS));
    rd_addr = row_base_r + AW'(c_cl);
  end

  // Row base and joint weight for the current tap
  always_ff @(posedge clk) begin
    logic [2*DW-1:0] prod;
    prod = {1'b0, r_cl} * w_eff;
    if (state_r == ST_ROW) begin
      row_base_r <= prod[AW-1:0];
      wxy_r      <= wgt_r[wy_sel] * wgt_r[wx_sel];
    end
  end

  // Pixel store: write each accepted pixel of the frame, register the read of the current tap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_if.in_red, in_if.in_green, in_if.in_blue};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign mac_ctl.clear  = advance && !warming;
  assign mac_ctl.mul_en = (state_r == ST_MUL);
  assign mac_ctl.acc_en = (state_r == ST_ACC);

  gbc_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .px    (rd_data_r),
    .wxy   (wxy_r),
    .red   (mac_red),
    .green (mac_green),
    .blue  (mac_blue)
  );

  // Sequence the taps
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (advance && !warming) state_nxt = ST_ROW;
      ST_ROW:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (dy_r == gbc_pkg::TAP_LAST && dx_r == gbc_pkg::TAP_LAST)
                           ? ST_DONE : ST_ROW;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= DW'(gbc_pkg::MAX_WIDTH);
      height_r    <= DW'(gbc_pkg::MAX_HEIGHT);
      wgt_r[0]    <= gbc_pkg::RST_WEIGHT_CTR;
      wgt_r[1]    <= gbc_pkg::RST_WEIGHT_ONE;
      wgt_r[2]    <= gbc_pkg::RST_WEIGHT_TWO;
      wgt_r[3]    <= gbc_pkg::RST_WEIGHT_THREE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      warm_r      <= '0;
      dy_r        <= '0;
      dx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (cfg_index)
          gbc_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data[DW-1:0];
          gbc_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[DW-1:0];
          gbc_pkg::REG_WEIGHT_CTR:   wgt_r[0] <= cfg_data;
          gbc_pkg::REG_WEIGHT_ONE:   wgt_r[1] <= cfg_data;
          gbc_pkg::REG_WEIGHT_TWO:   wgt_r[2] <= cfg_data;
          gbc_pkg::REG_WEIGHT_THREE: wgt_r[3] <= cfg_data;
          default: ;
        endcase
      end

      // Advance the input position
      if (wr_en) begin
        if (DW'(in_col_r) + DW'(1) >= w_eff) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + DW'(1);
        end else begin
          in_col_r <= in_col_r + PW'(1);
        end
      end

      if (advance && warming) warm_r <= warm_r + WW'(1);

      if (advance && !warming) begin
        dy_r <= '0;
        dx_r <= '0;
      end else if (state_r == ST_ACC) begin
        if (dx_r == gbc_pkg::TAP_LAST) begin
          dx_r <= '0;
          dy_r <= dy_r + TW'(1);
        end else begin
          dx_r <= dx_r + TW'(1);
        end
      end

      // Drop a delivered beat, load a finished one
      if (out_valid_r && out_if.ready && !(state_r == ST_DONE && out_free)) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        if (last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          warm_r    <= '0;
        end else if (DW'(out_col_r) + DW'(1) >= w_eff) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + PW'(1);
        end else begin
          out_col_r <= out_col_r + PW'(1);
        end
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_red_r   <= mac_red;
      out_green_r <= mac_green;
      out_blue_r  <= mac_blue;
      out_last_r  <= last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.out_red    = out_red_r;
  assign out_if.out_green  = out_green_r;
  assign out_if.out_blue   = out_blue_r;
  assign out_if.last_pixel = out_last_r;

  a_done_warm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> warm_r >= lag)
    else $error("window computed before warmup finished");

  // The tap counters step past the window on the final accumulate
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_DONE)
      |-> dy_r <= gbc_pkg::TAP_LAST && dx_r <= gbc_pkg::TAP_LAST)
    else $error("tap index out of window");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_if.ready) |=> state_r == ST_DONE)
    else $error("result finished over an undelivered beat");

endmodule

>>> tb/tb_gaussian_blur_clamped_top.sv
module tb_gaussian_blur_clamped_top;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_px_t;

  typedef enum logic [1:0] {ROW_REG, ROW_PIXEL, ROW_FLUSH} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [2:0] idx;
    logic [15:0] data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         typed;
    blur_px_t   want;
  } stim_row_t;

  localparam int LONG_HOLD = 3000;
  localparam int DRAIN_WAIT = 220;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  gbc_in_if in_if();
  gbc_out_if out_if();

  gaussian_blur_clamped_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: registers, counters and pixel store
  logic [12:0] reg_width;
  logic [12:0] reg_height;
  logic [15:0] tap_wt [4];
  logic [23:0] pix_store [gbc_pkg::STORE_DEPTH];
  int unsigned in_col, in_row, out_col, out_row, warm_cnt;

  blur_px_t blur_expected [$];
  int error_count = 0;
  int beat_count = 0;
  int frame_count = 0;
  int checked_count = 0;
  bit tx_busy = 1'b0;
  bit rx_busy = 1'b0;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned clamp_pos(input int v, input int unsigned lim);
    if (v < 0) return 0;
    if (v > int'(lim) - 1) return lim - 1;
    return v;
  endfunction

  // Advance the predictor by one accepted beat
  function automatic void blur_step(input logic [7:0] r, g, b, input logic fl,
                                    output bit got, output blur_px_t res);
    int unsigned w, h, lag, rr, cc, col;
    longint unsigned acc [3];
    longint unsigned wxy;
    logic [23:0] px;
    bit last;
    w = (reg_width == 0) ? 1 :
        ((reg_width > gbc_pkg::MAX_WIDTH) ? gbc_pkg::MAX_WIDTH : reg_width);
    h = (reg_height == 0) ? 1 :
        ((reg_height > gbc_pkg::MAX_HEIGHT) ? gbc_pkg::MAX_HEIGHT : reg_height);
    lag = gbc_pkg::HALF_TAPS * w + gbc_pkg::HALF_TAPS;
    got = 1'b0;
    res = '0;
    if (in_row < h) begin
      if (fl) return;
      col = (in_col < w) ? in_col : w - 1;
      pix_store[(in_row * w + col) % gbc_pkg::STORE_DEPTH] = {r, g, b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (warm_cnt < lag) begin
      warm_cnt++;
      return;
    end
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    for (int dy = -gbc_pkg::HALF_TAPS; dy <= gbc_pkg::HALF_TAPS; dy++) begin
      rr = clamp_pos(int'(out_row) + dy, h);
      for (int dx = -gbc_pkg::HALF_TAPS; dx <= gbc_pkg::HALF_TAPS; dx++) begin
        cc = clamp_pos(int'(out_col) + dx, w);
        wxy = longint'(tap_wt[dy < 0 ? -dy : dy]) * longint'(tap_wt[dx < 0 ? -dx : dx]);
        px = pix_store[(rr * w + cc) % gbc_pkg::STORE_DEPTH];
        acc[0] += longint'(px[23:16]) * wxy;
        acc[1] += longint'(px[15:8]) * wxy;
        acc[2] += longint'(px[7:0]) * wxy;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = (acc[ch] + 64'h8000_0000) >> 32;
      if (acc[ch] > 255) acc[ch] = 255;
    end
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res = '{acc[0][7:0], acc[1][7:0], acc[2][7:0], last};
    got = 1'b1;
    if (last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; warm_cnt = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // Write one register; caller lowers the enable after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      gbc_pkg::REG_IMAGE_WIDTH:  reg_width  = val[12:0];
      gbc_pkg::REG_IMAGE_HEIGHT: reg_height = val[12:0];
      gbc_pkg::REG_WEIGHT_CTR:   tap_wt[0]  = val;
      gbc_pkg::REG_WEIGHT_ONE:   tap_wt[1]  = val;
      gbc_pkg::REG_WEIGHT_TWO:   tap_wt[2]  = val;
      gbc_pkg::REG_WEIGHT_THREE: tap_wt[3]  = val;
      default: ;
    endcase
  endtask

  // Offer one beat, hold until taken, then predict; a busy sender then idles a random gap
  task automatic send_beat(input logic [7:0] r, g, b, input logic fl,
                           input bit typed, input blur_px_t want);
    bit got;
    blur_px_t res;
    int gap;
    in_if.valid    <= 1'b1;
    in_if.in_red   <= r;
    in_if.in_green <= g;
    in_if.in_blue  <= b;
    in_if.flush    <= fl;
    do @(posedge clk); while (!in_if.ready);
    blur_step(r, g, b, fl, got, res);
    if (got) blur_expected.push_back(typed ? want : res);
    beat_count++;
    gap = tx_busy ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every result is back and the block is quiet
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_weight(input int mode, input int tap);
    case (mode)
      0: return (tap == 0) ? gbc_pkg::RST_WEIGHT_CTR :
                (tap == 1) ? gbc_pkg::RST_WEIGHT_ONE :
                (tap == 2) ? gbc_pkg::RST_WEIGHT_TWO : gbc_pkg::RST_WEIGHT_THREE;
      1: return 16'($urandom_range(0, 16'hFFFF));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 12000));
    endcase
  endfunction

  // Receiver: random gaps per beat when busy, plus one long hold on request
  int rx_gap = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) rx_gap = rx_busy ? $urandom_range(0, 3) : 0;
    if (hold_req) begin
      rx_hold = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_n;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    blur_px_t exp_px;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (blur_expected.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_px = blur_expected.pop_front();
        checked_count++;
        if (out_if.out_red !== exp_px.red)
          report_mismatch($sformatf("red %0d, want %0d", out_if.out_red, exp_px.red));
        if (out_if.out_green !== exp_px.green)
          report_mismatch($sformatf("green %0d, want %0d", out_if.out_green, exp_px.green));
        if (out_if.out_blue !== exp_px.blue)
          report_mismatch($sformatf("blue %0d, want %0d", out_if.out_blue, exp_px.blue));
        if (out_if.last_pixel !== exp_px.last)
          report_mismatch($sformatf("last_pixel %0b, want %0b", out_if.last_pixel,
                                    exp_px.last));
      end
    end
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  stim_row_t dir_rows [$];

  function automatic void add_reg(input logic [2:0] idx, input logic [15:0] val);
    dir_rows.push_back('{ROW_REG, idx, val, 8'd0, 8'd0, 8'd0, 1'b0, '0});
  endfunction

  function automatic void add_beat(input row_kind_t k, input logic [7:0] r, g, b,
                                   input bit typed, input blur_px_t want);
    dir_rows.push_back('{k, 3'd0, 16'd0, r, g, b, typed, want});
  endfunction

  initial begin
    bit prev_reg;
    int w, h, lag, mode;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = gbc_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.in_red = '0;
    in_if.in_green = '0;
    in_if.in_blue = '0;
    in_if.flush = 1'b0;
    out_if.ready = 1'b0;
    reg_width = 13'd4096;
    reg_height = 13'd4096;
    tap_wt[0] = gbc_pkg::RST_WEIGHT_CTR;
    tap_wt[1] = gbc_pkg::RST_WEIGHT_ONE;
    tap_wt[2] = gbc_pkg::RST_WEIGHT_TWO;
    tap_wt[3] = gbc_pkg::RST_WEIGHT_THREE;
    foreach (pix_store[i]) pix_store[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; warm_cnt = 0;

    // Directed: 1x1 frames (zero size clamps to one), center-only weights pass
    // pixels through; all-max weights scale by 49 and saturate.
    add_reg(gbc_pkg::REG_IMAGE_WIDTH, 16'd0);
    add_reg(gbc_pkg::REG_IMAGE_HEIGHT, 16'd0);
    add_reg(gbc_pkg::REG_WEIGHT_CTR, 16'hFFFF);
    add_reg(gbc_pkg::REG_WEIGHT_ONE, 16'h0000);
    add_reg(gbc_pkg::REG_WEIGHT_TWO, 16'h0000);
    add_reg(gbc_pkg::REG_WEIGHT_THREE, 16'h0000);
    add_beat(ROW_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);      // early flush, ignored
    add_beat(ROW_PIXEL, 8'd255, 8'd0, 8'd128, 1'b0, '0);
    add_beat(ROW_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0, '0);      // past frame end, dropped
    repeat (4) add_beat(ROW_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
    add_beat(ROW_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd255, 8'd0, 8'd128, 1'b1});
    add_beat(ROW_PIXEL, 8'd0, 8'd255, 8'd1, 1'b0, '0);
    repeat (5) add_beat(ROW_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
    add_beat(ROW_PIXEL, 8'd9, 8'd9, 8'd9, 1'b1, '{8'd0, 8'd255, 8'd1, 1'b1});
    add_reg(gbc_pkg::REG_WEIGHT_ONE, 16'hFFFF);
    add_reg(gbc_pkg::REG_WEIGHT_TWO, 16'hFFFF);
    add_reg(gbc_pkg::REG_WEIGHT_THREE, 16'hFFFF);
    add_beat(ROW_PIXEL, 8'd5, 8'd6, 8'd0, 1'b0, '0);
    repeat (5) add_beat(ROW_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
    add_beat(ROW_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd245, 8'd255, 8'd0, 1'b1});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    prev_reg = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        if (!prev_reg) wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_wr_en <= 1'b0;
        prev_reg = 1'b0;
        send_beat(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                  dir_rows[i].kind == ROW_FLUSH, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random frames: new settings each frame, written while idle
    while (beat_count < 1400) begin
      wait_drained();
      frame_count++;
      if (frame_count == 3) begin
        w = 64;
        h = 2;
      end else begin
        w = $urandom_range(0, 8);
        h = $urandom_range(0, 6);
      end
      mode = $urandom_range(0, 3);
      write_reg(gbc_pkg::REG_IMAGE_WIDTH, 16'(w));
      write_reg(gbc_pkg::REG_IMAGE_HEIGHT, 16'(h));
      write_reg(gbc_pkg::REG_WEIGHT_CTR, pick_weight(mode, 0));
      write_reg(gbc_pkg::REG_WEIGHT_ONE, pick_weight(mode, 1));
      write_reg(gbc_pkg::REG_WEIGHT_TWO, pick_weight(mode, 2));
      write_reg(gbc_pkg::REG_WEIGHT_THREE, pick_weight(mode, 3));
      cfg_wr_en <= 1'b0;
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      lag = gbc_pkg::HALF_TAPS * w + gbc_pkg::HALF_TAPS;
      tx_busy = $urandom_range(0, 2) != 0;
      rx_busy = $urandom_range(0, 2) != 0;
      if (frame_count == 3) hold_req = 1'b1;
      // Pixels with occasional early flushes mixed in
      for (int p = 0; p < w * h; p++) begin
        if ($urandom_range(0, 99) < 8)
          send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, '0);
        send_beat(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
      end
      // Drain with flushes; stray pixels here are dropped
      for (int p = 0; p < lag; p++)
        send_beat(8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(0, 99) >= 15, 1'b0, '0);
    end

    wait_drained();
    $display("Ran %0d beats over %0d random frames plus directed 1x1 frames;",
             beat_count, frame_count);
    $display("checked %0d blurred pixels, %0d mismatches", checked_count, error_count);
    if (error_count == 0 && blur_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
